>>> hdl/bpl_pkg.sv
// Shared types and constants of the barycentric point location unit.
package bpl_pkg;

	localparam int TOL_W   = 16;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLAIN     = 8'd1;

	typedef enum logic [2:0] {
		LOC_INSIDE  = 3'd0,
		LOC_OUTSIDE = 3'd1,
		LOC_EDGE_AB = 3'd2,
		LOC_EDGE_CA = 3'd3,
		LOC_EDGE_BC = 3'd4
	} loc_t;

	typedef struct packed {
		logic [TOL_W-1:0] tolerance;
		logic             plain;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> hdl/bpl_front.sv
// Front end: edge vectors, cross products, signs and degenerate flag.
module bpl_front import bpl_pkg::*; #(
	parameter int CW = 16,
	parameter int NW = 2*CW+2,
	parameter int IW = 3*NW+3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [8*CW-1:0] s_tdata,
	input  q_stat_t       qstat,
	output logic          push,
	output logic [IW-1:0] item
);

	localparam int DW = CW + 1;
	localparam int PW = 2*DW;
	localparam int SW = PW + 1;

	logic signed [CW-1:0] c [8];
	logic                 adv;
	logic                 valid_s1, valid_s2, valid_s3;
	logic signed [DW-1:0] v0x_s1, v0y_s1, v1x_s1, v1y_s1, v2x_s1, v2y_s1;
	logic signed [PW-1:0] da_s2, db_s2, ua_s2, ub_s2, va_s2, vb_s2;
	logic signed [SW-1:0] den_s3, nu_s3, nv_s3;
	logic [SW-1:0]        dm, um, vm;
	logic                 deg;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			c[i] = signed'(s_tdata[i*CW +: CW]);
		end
	end

	assign adv      = !(valid_s3 && qstat.full);
	assign s_tready = adv;
	assign push     = valid_s3 && !qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v0x_s1 <= DW'(c[4]) - DW'(c[0]);
			v0y_s1 <= DW'(c[5]) - DW'(c[1]);
			v1x_s1 <= DW'(c[2]) - DW'(c[0]);
			v1y_s1 <= DW'(c[3]) - DW'(c[1]);
			v2x_s1 <= DW'(c[6]) - DW'(c[0]);
			v2y_s1 <= DW'(c[7]) - DW'(c[1]);
			da_s2  <= PW'(v1x_s1) * PW'(v0y_s1);
			db_s2  <= PW'(v1y_s1) * PW'(v0x_s1);
			ua_s2  <= PW'(v1x_s1) * PW'(v2y_s1);
			ub_s2  <= PW'(v1y_s1) * PW'(v2x_s1);
			va_s2  <= PW'(v2x_s1) * PW'(v0y_s1);
			vb_s2  <= PW'(v2y_s1) * PW'(v0x_s1);
			den_s3 <= SW'(da_s2) - SW'(db_s2);
			nu_s3  <= SW'(ua_s2) - SW'(ub_s2);
			nv_s3  <= SW'(va_s2) - SW'(vb_s2);
		end
	end

	assign dm  = den_s3[SW-1] ? -den_s3 : den_s3;
	assign um  = nu_s3[SW-1]  ? -nu_s3  : nu_s3;
	assign vm  = nv_s3[SW-1]  ? -nv_s3  : nv_s3;
	assign deg = (den_s3 == '0);

	assign item = {deg, nu_s3[SW-1] ^ den_s3[SW-1], nv_s3[SW-1] ^ den_s3[SW-1],
		dm[NW-1:0], um[NW-1:0], vm[NW-1:0]};

endmodule

>>> hdl/bpl_fifo.sv
// Four-entry queue between front end and divider back end.
module bpl_fifo import bpl_pkg::*; #(
	parameter int IW = 102
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [IW-1:0] wdata,
	input  logic          pop,
	output logic [IW-1:0] rdata,
	output q_stat_t       qstat
);

	logic [IW-1:0] mem [4];
	logic [1:0]    wp_q, rp_q;
	logic [2:0]    cnt_q;

	assign qstat.full  = (cnt_q == 3'd4);
	assign qstat.empty = (cnt_q == 3'd0);
	assign rdata       = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop)  rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(push) - 3'(pop);
		end
	end

endmodule

>>> hdl/bpl_back.sv
// Back end: pipelined restoring dividers for u and v, then classification.
module bpl_back import bpl_pkg::*; #(
	parameter int NW = 34,
	parameter int FB = 32,
	parameter int IW = 3*NW+3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  q_stat_t       qstat,
	input  logic [IW-1:0] item,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [7:0]    m_tdata
);

	localparam int QW = NW + FB;
	localparam int W2 = QW + 2;

	logic              adv;
	logic              valid_s [QW+1];
	logic [NW-1:0]     d_s     [QW+1];
	logic [NW-1:0]     ru_s    [QW+1];
	logic [NW-1:0]     rv_s    [QW+1];
	logic [NW-1:0]     nu_s    [QW+1];
	logic [NW-1:0]     nv_s    [QW+1];
	logic [QW-1:0]     qu_s    [QW+1];
	logic [QW-1:0]     qv_s    [QW+1];
	logic              negu_s  [QW+1];
	logic              negv_s  [QW+1];
	logic              deg_s   [QW+1];

	logic              valid_sg, deg_sg;
	logic signed [W2-1:0] u_sg, v_sg, s_sg;
	logic signed [W2-1:0] one, tol, ntol;
	logic              on_ab, on_ca, on_bc, in_tri;
	loc_t              loc;
	logic              out_valid_q;
	logic [2:0]        loc_q;
	logic              deg_q;

	assign adv = !out_valid_q || m_tready;
	assign pop = adv && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (adv) begin
			valid_s[0] <= !qstat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s[0]  <= item[IW-1];
			negu_s[0] <= item[IW-2];
			negv_s[0] <= item[IW-3];
			d_s[0]    <= item[3*NW-1:2*NW];
			nu_s[0]   <= item[2*NW-1:NW];
			nv_s[0]   <= item[NW-1:0];
			ru_s[0]   <= '0;
			rv_s[0]   <= '0;
			qu_s[0]   <= '0;
			qv_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NW:0] tu, tv;
		logic        geu, gev;

		assign tu  = {ru_s[k], nu_s[k][NW-1]};
		assign tv  = {rv_s[k], nv_s[k][NW-1]};
		assign geu = (tu >= {1'b0, d_s[k]});
		assign gev = (tv >= {1'b0, d_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (adv) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ru_s[k+1]   <= geu ? NW'(tu - {1'b0, d_s[k]}) : NW'(tu);
				rv_s[k+1]   <= gev ? NW'(tv - {1'b0, d_s[k]}) : NW'(tv);
				nu_s[k+1]   <= {nu_s[k][NW-2:0], 1'b0};
				nv_s[k+1]   <= {nv_s[k][NW-2:0], 1'b0};
				qu_s[k+1]   <= {qu_s[k][QW-2:0], geu};
				qv_s[k+1]   <= {qv_s[k][QW-2:0], gev};
				d_s[k+1]    <= d_s[k];
				negu_s[k+1] <= negu_s[k];
				negv_s[k+1] <= negv_s[k];
				deg_s[k+1]  <= deg_s[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sg <= 1'b0;
		end else if (adv) begin
			valid_sg <= valid_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		logic signed [W2-1:0] ua, va;
		if (adv) begin
			ua = negu_s[QW] ? -signed'(W2'(qu_s[QW])) : signed'(W2'(qu_s[QW]));
			va = negv_s[QW] ? -signed'(W2'(qv_s[QW])) : signed'(W2'(qv_s[QW]));
			u_sg   <= ua;
			v_sg   <= va;
			s_sg   <= ua + va;
			deg_sg <= deg_s[QW];
		end
	end

	assign one  = signed'(W2'(1) << FB);
	assign tol  = signed'(W2'(cfg.tolerance));
	assign ntol = -tol;

	assign on_ab = (u_sg >= ntol) && (u_sg <= tol) &&
		(cfg.plain || ((v_sg <= one) && (v_sg > 0)));
	assign on_ca = (v_sg >= ntol) && (v_sg <= tol) &&
		(cfg.plain || ((u_sg <= one) && (u_sg > 0)));
	assign on_bc  = (s_sg >= one - tol) && (s_sg <= one + tol);
	assign in_tri = (u_sg >= tol) && (v_sg >= tol) && (s_sg <= one);

	always_comb begin
		if (deg_sg)      loc = LOC_OUTSIDE;
		else if (on_ab)  loc = LOC_EDGE_AB;
		else if (on_ca)  loc = LOC_EDGE_CA;
		else if (on_bc)  loc = LOC_EDGE_BC;
		else if (in_tri) loc = LOC_INSIDE;
		else             loc = LOC_OUTSIDE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_sg;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			loc_q <= loc;
			deg_q <= deg_sg;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, deg_q, loc_q};

endmodule

>>> hdl/barycentric_point_location_unit.sv
// Top level of the barycentric point location unit.
//
//  channel  | direction | beat
//  s_       | in        | tdata: ax, ay, bx, by_coord, cx, cy, px, py (COORD_WIDTH each)
//  m_       | out       | tdata: location[2:0], degenerate[3], zeros above
//  cfg_     | in        | write: index 0 tolerance, index 1 plain_edge_rules
//
// One beat per cycle sustained while m_tready stays high; each beat passes through the
// one-quotient-bit-per-stage divider pipeline (66 stages by default).
// The front end and divider each stall on their own around a four-entry queue.
// Reset clears valid bits, queue pointers and both registers.
module barycentric_point_location_unit import bpl_pkg::*; #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [8*COORD_WIDTH-1:0] s_tdata,   // ax, ay, bx, by_coord, cx, cy, px, py
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [7:0]               m_tdata,   // location[2:0], degenerate[3]
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [TOL_W-1:0]         cfg_wdata
);

	localparam int NW = 2*COORD_WIDTH + 2;
	localparam int IW = 3*NW + 3;

	cfg_t          cfg_q;
	q_stat_t       qstat;
	logic          push, pop;
	logic [IW-1:0] wdata, rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOLERANCE: cfg_q.tolerance <= cfg_wdata;
				REG_PLAIN:     cfg_q.plain     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	bpl_front #(.CW(COORD_WIDTH), .NW(NW), .IW(IW)) u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.qstat, .push, .item(wdata)
	);

	bpl_fifo #(.IW(IW)) u_fifo (
		.clk, .arst_n, .push, .wdata, .pop, .rdata, .qstat
	);

	bpl_back #(.NW(NW), .FB(FRAC_BITS), .IW(IW)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .qstat, .item(rdata), .pop,
		.m_tvalid, .m_tready, .m_tdata
	);

endmodule

>>> hdl/bpl_checker.sv
// Port checker for the barycentric point location unit and its bind.
module bpl_checker import bpl_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed while stalled");

	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> m_tdata[2:0] == LOC_OUTSIDE)
		else $error("degenerate result not outside");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= LOC_EDGE_BC)
		else $error("location code out of range");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:4] == 4'b0000)
		else $error("padding bits set");

endmodule

bind barycentric_point_location_unit bpl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata)
);
